[hw/rtl/range_frame_deframer_level_defines.svh]
// Assertion macros shared by the deframer RTL.
// Included by the modules that check their own logic; needs nothing else.
`ifndef RANGE_FRAME_DEFRAMER_LEVEL_DEFINES_SVH
`define RANGE_FRAME_DEFRAMER_LEVEL_DEFINES_SVH

`ifndef SYNTHESIS
`define RFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rfd assertion failed");
`define RFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfd assertion failed");
`else
`define RFD_ASSERT(label, clk, rst, prop)
`define RFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/rfd_pkg.sv]
// Types, constants and register codes for the range frame deframer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rfd_pkg;

   localparam int FRAME_LENGTH_DEF = 9;

   localparam int BYTE_W     = 8;
   localparam int DIST_W     = 16;
   localparam int OFFSET_W   = 15;
   localparam int SCALE_W    = 20;
   localparam int LEVEL_W    = 20;
   localparam int CSR_DATA_W = 20;
   localparam int PROD_W     = DIST_W + SCALE_W;
   localparam int FRAC_W     = 16;

   // Byte positions within a frame that carry the distance, high byte first.
   localparam int DIST_HI_POS = 5;
   localparam int DIST_LO_POS = 6;

   localparam logic [BYTE_W-1:0]          START_BYTE_RST   = 8'h62;
   localparam logic [DIST_W-1:0]          RANGE_LIMIT_RST  = 16'd4000;
   localparam logic signed [OFFSET_W-1:0] LEVEL_OFFSET_RST = 15'sd1964;
   localparam logic [SCALE_W-1:0]         MM_SCALE_RST     = 20'd258017;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 20'sh7FFFF;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 20'sh80000;

   typedef enum logic [1:0] {
      REG_START_BYTE   = 2'd0,
      REG_RANGE_LIMIT  = 2'd1,
      REG_LEVEL_OFFSET = 2'd2,
      REG_MM_SCALE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]          start_byte;
      logic [DIST_W-1:0]          range_limit_mm;
      logic signed [OFFSET_W-1:0] level_offset;
      logic [SCALE_W-1:0]         mm_scale_q16;
   } cfg_type;

   // Handed from the frame tracker to the level stage when a frame closes.
   typedef struct packed {
      logic              fire;
      logic              bad;
      logic [DIST_W-1:0] distance;
   } frame_done_type;

endpackage

[hw/rtl/range_frame_deframer_level.sv]
// Range frame deframer with level output: one received byte is taken per cycle, unless a checksum byte waits.
// A checksum byte passes through the input register, then the result register, and waits while that is full.
// Throughput: one byte per cycle; only the result register stall holds back a checksum byte.
// Reset is synchronous and active high: configuration and valid flags return to defaults, the tracker hunts.
// The multiply, rounding and saturation sit in one stage before the result register.
`timescale 1ns / 1ps

module range_frame_deframer_level
   import rfd_pkg::*;
#(
   parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte[7:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // distance_mm[15:0], level_hundredths[35:16]
   output logic [1:0]            rsp_tuser,   // frame_status[0], level_valid[1]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type        cfg;
   frame_done_type done;
   logic           out_free;

   rfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rfd_frame #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .out_free   (out_free),
      .done       (done)
   );

   rfd_level u_level (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .done       (done),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hw/rtl/rfd_csr.sv]
// Configuration registers of the deframer, written through the csr channel.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_csr
   import rfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_START_BYTE:   cfg_in.start_byte     = csr_data[BYTE_W-1:0];
            REG_RANGE_LIMIT:  cfg_in.range_limit_mm = csr_data[DIST_W-1:0];
            REG_LEVEL_OFFSET: cfg_in.level_offset   = $signed(csr_data[OFFSET_W-1:0]);
            REG_MM_SCALE:     cfg_in.mm_scale_q16   = csr_data[SCALE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= START_BYTE_RST;
         cfg_ff.range_limit_mm <= RANGE_LIMIT_RST;
         cfg_ff.level_offset   <= LEVEL_OFFSET_RST;
         cfg_ff.mm_scale_q16   <= MM_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/rfd_frame.sv]
// Input register and frame tracker: start byte hunt, running XOR and distance capture.
// Depends on rfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "range_frame_deframer_level_defines.svh"

module rfd_frame
   import rfd_pkg::*;
#(
   parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  cfg_type           cfg,
   input  logic              out_free,
   output frame_done_type    done
);

   localparam int PosW = $clog2(FRAME_LENGTH);
   localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] dist_hi_ff, dist_hi_in;
   logic [BYTE_W-1:0] dist_lo_ff, dist_lo_in;
   logic              is_last;
   logic              move;
   logic              accept;

   assign is_last    = (pos_ff == LastPos);
   // A checksum byte may only leave the input register when the result register is free.
   assign move       = in_valid_ff && (!is_last || out_free);
   assign req_tready = !in_valid_ff || move;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign in_byte_in  = accept ? req_tdata : in_byte_ff;

   always_comb begin
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      dist_hi_in    = dist_hi_ff;
      dist_lo_in    = dist_lo_ff;
      done.fire     = 1'b0;
      done.bad      = (xor_ff != in_byte_ff);
      done.distance = {dist_hi_ff, dist_lo_ff};
      if (move) begin
         if (pos_ff == '0) begin
            if (in_byte_ff == cfg.start_byte) begin
               xor_in = in_byte_ff;
               pos_in = PosW'(1);
            end
         end else if (!is_last) begin
            xor_in = xor_ff ^ in_byte_ff;
            if (pos_ff == PosW'(DIST_HI_POS)) begin
               dist_hi_in = in_byte_ff;
            end else if (pos_ff == PosW'(DIST_LO_POS)) begin
               dist_lo_in = in_byte_ff;
            end
            pos_in = pos_ff + PosW'(1);
         end else begin
            pos_in    = '0;
            done.fire = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         xor_ff      <= '0;
         dist_hi_ff  <= '0;
         dist_lo_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         xor_ff      <= xor_in;
         dist_hi_ff  <= dist_hi_in;
         dist_lo_ff  <= dist_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   `RFD_ASSERT(a_pos_in_frame, clock, reset, pos_ff <= LastPos)
   `RFD_ASSERT_NEXT(a_hunt_after_frame, clock, reset, done.fire, pos_ff == '0)
   `RFD_ASSERT(a_fire_needs_room, clock, reset, !done.fire || out_free)

endmodule

[hw/rtl/rfd_level.sv]
// Level arithmetic and result register: Q16 scaling, rounding, saturation.
// Depends on rfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "range_frame_deframer_level_defines.svh"

module rfd_level
   import rfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  frame_done_type done,
   output logic           out_free,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [39:0]    rsp_tdata,  // distance_mm[15:0], level_hundredths[35:16], zero pad
   output logic [1:0]     rsp_tuser   // frame_status[0], level_valid[1]
);

   localparam int DiffW = LEVEL_W + 2;

   logic                      valid_ff, valid_in;
   logic                      status_ff, status_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic                      lvl_ok_ff, lvl_ok_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;

   logic [PROD_W-1:0]         prod;
   logic [PROD_W-1:0]         rounded;
   logic [LEVEL_W-1:0]        scaled;
   logic signed [DiffW-1:0]   diff;
   logic signed [LEVEL_W-1:0] level_sat;
   logic                      in_range;

   assign out_free = !valid_ff || rsp_tready;

   assign prod     = PROD_W'(done.distance) * PROD_W'(cfg.mm_scale_q16);
   // The product stays below 2^36 even after the half is added, so no carry is lost.
   assign rounded  = prod + ROUND_HALF;
   assign scaled   = rounded[FRAC_W +: LEVEL_W];
   assign diff     = DiffW'(cfg.level_offset) - $signed({2'b00, scaled});
   assign in_range = (done.distance < cfg.range_limit_mm);

   always_comb begin
      if (diff > DiffW'(LEVEL_MAX)) begin
         level_sat = LEVEL_MAX;
      end else if (diff < DiffW'(LEVEL_MIN)) begin
         level_sat = LEVEL_MIN;
      end else begin
         level_sat = diff[LEVEL_W-1:0];
      end
   end

   always_comb begin
      valid_in  = done.fire ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      status_in = status_ff;
      dist_in   = dist_ff;
      lvl_ok_in = lvl_ok_ff;
      level_in  = level_ff;
      if (done.fire) begin
         status_in = done.bad;
         if (done.bad) begin
            dist_in   = '0;
            lvl_ok_in = 1'b0;
            level_in  = '0;
         end else begin
            dist_in   = done.distance;
            lvl_ok_in = in_range;
            level_in  = in_range ? level_sat : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dist_ff   <= dist_in;
      lvl_ok_ff <= lvl_ok_in;
      level_ff  <= level_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, level_ff, dist_ff};
   assign rsp_tuser  = {lvl_ok_ff, status_ff};

   `RFD_ASSERT(a_bad_frame_zeroed, clock, reset,
      !(valid_ff && status_ff) || (dist_ff == '0 && !lvl_ok_ff && level_ff == '0))
   `RFD_ASSERT(a_no_level_zeroed, clock, reset, !(valid_ff && !lvl_ok_ff) || level_ff == '0)
   `RFD_ASSERT(a_level_in_range, clock, reset,
      !(valid_ff && lvl_ok_ff) || (dist_ff < cfg.range_limit_mm))

endmodule

[tb/range_frame_deframer_level_test.sv]
// Self-checking testbench for the range frame deframer with level output.
// Needs rfd_pkg and range_frame_deframer_level; a scoreboard class predicts each result.
`timescale 1ns / 1ps

typedef struct packed {
   logic                     status;
   logic [15:0]              distance;
   logic                     valid;
   logic signed [19:0]       level;
} level_result_type;

class level_scoreboard;
   localparam int FRAME_LEN = rfd_pkg::FRAME_LENGTH_DEF;

   logic [7:0]         start_byte;
   logic [15:0]        range_limit;
   logic signed [14:0] level_offset;
   logic [19:0]        mm_scale;

   int unsigned        byte_pos;
   logic [7:0]         xor_acc;
   logic [7:0]         dist_hi;
   logic [7:0]         dist_lo;

   level_result_type   expected_q[$];
   int unsigned        errors;

   function new();
      start_byte   = rfd_pkg::START_BYTE_RST;
      range_limit  = rfd_pkg::RANGE_LIMIT_RST;
      level_offset = rfd_pkg::LEVEL_OFFSET_RST;
      mm_scale     = rfd_pkg::MM_SCALE_RST;
      byte_pos     = 0;
      xor_acc      = '0;
      dist_hi      = '0;
      dist_lo      = '0;
      errors       = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void write_reg(rfd_pkg::csr_index_type idx, logic [19:0] v);
      case (idx)
         rfd_pkg::REG_START_BYTE:   start_byte   = v[7:0];
         rfd_pkg::REG_RANGE_LIMIT:  range_limit  = v[15:0];
         rfd_pkg::REG_LEVEL_OFFSET: level_offset = v[14:0];
         rfd_pkg::REG_MM_SCALE:     mm_scale     = v[19:0];
         default: ;
      endcase
   endfunction

   // Follows the frame tracker byte by byte; the checksum byte yields one result.
   function void note_byte(logic [7:0] b);
      longint           dist_val;
      longint           scaled;
      longint           lvl;
      level_result_type r;
      if (byte_pos == 0) begin
         if (b == start_byte) begin
            xor_acc  = b;
            byte_pos = 1;
         end
      end else if (byte_pos < FRAME_LEN - 1) begin
         xor_acc ^= b;
         if (byte_pos == rfd_pkg::DIST_HI_POS)
            dist_hi = b;
         else if (byte_pos == rfd_pkg::DIST_LO_POS)
            dist_lo = b;
         byte_pos++;
      end else begin
         byte_pos = 0;
         r = '0;
         if (xor_acc != b) begin
            r.status = 1'b1;
         end else begin
            dist_val   = longint'({dist_hi, dist_lo});
            r.distance = {dist_hi, dist_lo};
            if (dist_val < longint'(range_limit)) begin
               // Round half up on the Q16 product, then saturate to 20 bits signed.
               scaled = (dist_val * longint'(mm_scale) + 32768) >>> 16;
               lvl    = longint'(level_offset) - scaled;
               if (lvl > 524287)
                  lvl = 524287;
               if (lvl < -524288)
                  lvl = -524288;
               r.valid = 1'b1;
               r.level = lvl[19:0];
            end
         end
         expected_q.push_back(r);
      end
   endfunction

   task report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   task check_result(level_result_type got);
      level_result_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected result count", 1, 0);
      end else begin
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report_mismatch("frame_status", got.status, want.status);
         if (got.distance !== want.distance)
            report_mismatch("distance_mm", got.distance, want.distance);
         if (got.valid !== want.valid)
            report_mismatch("level_valid", got.valid, want.valid);
         if (got.level !== want.level)
            report_mismatch("level_hundredths", longint'(got.level), longint'(want.level));
      end
   endtask
endclass

module range_frame_deframer_level_test;
   import rfd_pkg::*;

   localparam int FRAME_LEN   = FRAME_LENGTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   level_scoreboard sb;
   bit              gaps_on;
   int unsigned     hold_asked;
   int unsigned     hold_served;
   int unsigned     bytes_sent;
   int unsigned     cycle_count;

   range_frame_deframer_level #(.FRAME_LENGTH(FRAME_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("range_frame_deframer_level_test failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   initial begin
      rsp_tready  = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= !gaps_on || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tuser[0], rsp_tdata[15:0], rsp_tuser[1], rsp_tdata[35:16]});
   end

   // Called at a falling edge; returns at a falling edge with the valid still high.
   task automatic push_byte(input logic [7:0] b);
      while (gaps_on && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [7:0] start, input logic [15:0] limit,
                                 input logic [14:0] offset, input logic [19:0] scale);
      write_csr(REG_START_BYTE, CSR_DATA_W'(start));
      write_csr(REG_RANGE_LIMIT, CSR_DATA_W'(limit));
      write_csr(REG_LEVEL_OFFSET, CSR_DATA_W'(offset));
      write_csr(REG_MM_SCALE, scale);
      csr_valid <= 1'b0;
   endtask

   // Finishes any open frame and waits for every result before settings change.
   task automatic drain();
      while (sb.byte_pos != 0)
         push_byte(8'($urandom));
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_frame(input logic [15:0] dist_mm, input bit corrupt,
                             input bit inner_start);
      logic [7:0] body [FRAME_LEN];
      logic [7:0] sum;
      body[0] = sb.start_byte;
      for (int i = 1; i < FRAME_LEN - 1; i++)
         body[i] = 8'($urandom);
      if (inner_start) begin
         body[1] = sb.start_byte;
         body[3] = sb.start_byte;
      end
      body[DIST_HI_POS] = dist_mm[15:8];
      body[DIST_LO_POS] = dist_mm[7:0];
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++)
         sum ^= body[i];
      body[FRAME_LEN-1] = corrupt ? sum ^ 8'($urandom_range(255, 1)) : sum;
      for (int i = 0; i < FRAME_LEN; i++)
         push_byte(body[i]);
   endtask

   function automatic logic [15:0] pick_distance();
      logic [15:0] lim;
      lim = sb.range_limit;
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return (lim == 0) ? 16'd0 : 16'($urandom_range(lim - 1));
         2: return lim;
         3: return (lim == 0) ? 16'd0 : lim - 16'd1;
         default: return 16'($urandom_range(300));
      endcase
   endfunction

   task automatic random_traffic(input int unsigned count, input bit with_hold);
      int unsigned stop_at;
      int unsigned hold_at;
      int          r;
      stop_at = bytes_sent + count;
      hold_at = bytes_sent + count / 3;
      while (bytes_sent < stop_at) begin
         if (with_hold && bytes_sent >= hold_at) begin
            hold_asked++;
            with_hold = 0;
         end
         r = $urandom_range(99);
         if (r < 70) begin
            send_frame(pick_distance(), $urandom_range(99) < 20, $urandom_range(99) < 5);
         end else if (r < 85) begin
            // Truncated frame: the next bytes are taken as its remaining data.
            push_byte(sb.start_byte);
            repeat ($urandom_range(FRAME_LEN - 2, 1))
               push_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(4, 1))
               push_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      sb          = new();
      gaps_on     = 1'b1;
      hold_asked  = 0;
      bytes_sent  = 0;
      cycle_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = REG_START_BYTE;
      csr_data    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings: hunting past noise, good and bad checksums, the range edge.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h5A);
      send_frame(16'd1000, 1'b0, 1'b0);
      send_frame(16'd1000, 1'b1, 1'b0);
      send_frame(16'd4000, 1'b0, 1'b0);
      send_frame(16'd3999, 1'b0, 1'b0);
      send_frame(16'd0, 1'b0, 1'b1);
      random_traffic(200, 1'b1);
      drain();

      // Largest scale with the lowest offset drives the level into saturation.
      write_settings(8'h00, 16'hFFFF, 15'h4000, 20'hFFFFF);
      send_frame(16'hFFFE, 1'b0, 1'b0);
      send_frame(16'hFFFF, 1'b0, 1'b0);
      send_frame(16'h0000, 1'b0, 1'b0);
      random_traffic(200, 1'b0);
      drain();

      // A zero range limit leaves every distance out of range.
      write_settings(8'hFF, 16'h0000, 15'h3FFF, 20'h00000);
      random_traffic(150, 1'b0);
      drain();

      for (int p = 0; p < 3; p++) begin
         write_settings(8'($urandom), 16'($urandom), 15'($urandom), 20'($urandom));
         gaps_on = (p != 1);
         random_traffic(150, p == 2);
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("range_frame_deframer_level_test passed");
      else
         $display("range_frame_deframer_level_test failed");
      $finish;
   end

endmodule
